[hdl/rwc_pkg.sv]
// Shared types and constants for the raycast wall column texturer.
`default_nettype none

package rwc_pkg;

  // Opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_W      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_H      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_PITCH  = 3'd6;

  // Field widths
  localparam int POS_W  = 24;
  localparam int ROW_W  = 12;
  localparam int TEX_W  = 13;
  localparam int PIX_X_W = 16;
  localparam int ADDR_W = 24;
  localparam int DIR_W  = 16;

  // Fixed-point positions
  localparam int DIR_FRAC  = 14;
  localparam int STEP_FRAC = 16;
  localparam int ACC_W     = 32;

  // Reset values
  localparam logic [ROW_W-1:0] VIEW_H_RST = 12'd480;
  localparam logic [TEX_W-1:0] TEX_RST    = 13'd64;
  localparam logic [ROW_W-1:0] H_MAX      = 12'd4095;

  // Shared divider: 29-bit dividend covers (tex_h << 16), 24-bit divisor covers distance
  localparam int DIV_N_W   = TEX_W + STEP_FRAC;
  localparam int DIV_D_W   = POS_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Shared multiplier operand widths (signed) and kept product bits
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = 32;

  // Parameter defaults
  localparam int STRIP_WIDTH_DEF = 1;
  localparam int FRAC_BITS_DEF   = 12;

  typedef struct packed {
    logic                    opcode;
    logic [11:0]             column_index;
    logic [POS_W-1:0]        ray_distance;
    logic signed [DIR_W-1:0] ray_dir_x;
    logic signed [DIR_W-1:0] ray_dir_y;
    logic                    ray_side;
    logic [ADDR_W-1:0]       texture_base;
  } in_data_t;

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [ROW_W-1:0]   pixel_y;
    logic [ADDR_W-1:0]  texel_address;
    logic               last_row;
  } out_data_t;

endpackage

`default_nettype wire

[hdl/raycast_wall_column_texturer.sv]
// Top level: column setup sequencer, row emitter and configuration registers.
// Column start: in_ready low through the setup (3 setup steps, two divides, 1 finish);
//   a zero-height column frees the block after the first divide.
// Row tick: the emit state loads the result into the output register, holding while the previous
//   result waits; in_ready stays low until then. It uses the registered shared multiplier for row * pitch.
// Reset (synchronous, rst_n low): idle, no column active, output empty, registers to defaults.
`default_nettype none

module raycast_wall_column_texturer
  import rwc_pkg::*;
#(
  parameter int STRIP_WIDTH = STRIP_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_data_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_data_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer: setup walks HIT -> FRAC -> COL -> DIVH -> DIVS -> ACC, a row tick uses ROUT.
  typedef enum logic [2:0] {
    S_IDLE, S_HIT, S_FRAC, S_COL, S_DIVH, S_DIVS, S_ACC, S_ROUT
  } state_t;

  localparam int HALF_W = ROW_W - 1;

  state_t state_r, state_nxt;

  // configuration
  logic [POS_W-1:0] px_r, px_nxt, py_r, py_nxt, ps_r, ps_nxt;
  logic [ROW_W-1:0] vh_r, vh_nxt;
  logic [TEX_W-1:0] tw_r, tw_nxt, th_r, th_nxt, tp_r, tp_nxt;

  // latched ray
  logic [POS_W-1:0]        dist_r, dist_nxt;
  logic signed [DIR_W-1:0] dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic                    side_r, side_nxt;

  // column state
  logic [PIX_X_W-1:0] column_x_r, column_x_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ROW_W-1:0]   texel_col_r, texel_col_nxt;
  logic [ROW_W-1:0]   top_row_r, top_row_nxt;
  logic [ROW_W-1:0]   rows_left_r, rows_left_nxt;
  logic [ROW_W-1:0]   row_done_r, row_done_nxt;
  logic [ROW_W-1:0]   h_r, h_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt, step_r, step_nxt;

  // output register
  out_data_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // shared units
  logic                      div_start, div_busy, div_done;
  logic [DIV_N_W-1:0]        div_n, div_q;
  logic [DIV_D_W-1:0]        div_d;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0]        mul_p;

  // datapath helpers
  logic                 in_fire, out_load, mirror;
  logic [TEX_W-1:0]     trow, col_raw, col_mir;
  logic [FRAC_BITS-1:0] frac;
  logic [ROW_W-1:0]     div_h;
  logic [HALF_W-1:0]    half_v, half_h, top, off;

  rwc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  rwc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = !out_valid_r || out_ready;

  // texture row of the current accumulator, masked by texture height - 1
  assign trow = acc_r[STEP_FRAC +: TEX_W] & (th_r - 13'd1);

  // hit fraction: player fraction plus bits of (dist * dir) >> 14
  assign frac = (side_r ? px_r[FRAC_BITS-1:0] : py_r[FRAC_BITS-1:0])
              + mul_p[DIR_FRAC +: FRAC_BITS];

  // texture column from (frac * tex_w) >> FRAC_BITS, mirrored on two faces
  assign col_raw = mul_p[FRAC_BITS +: TEX_W];
  assign col_mir = tw_r - col_raw - 13'd1;
  assign mirror  = (!side_r && dir_x_r[DIR_W-1])
                || (side_r && !dir_y_r[DIR_W-1] && (dir_y_r != '0));

  // wall height saturates at 4095 (a zero distance divides to all ones)
  assign div_h = (|div_q[DIV_N_W-1:ROW_W]) ? H_MAX : div_q[ROW_W-1:0];

  assign half_v = vh_r[ROW_W-1:1];
  assign half_h = h_r[ROW_W-1:1];
  assign top    = (half_v > half_h) ? (half_v - half_h) : '0;
  assign off    = (half_v > half_h) ? '0 : (half_h - half_v);

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ps_nxt        = ps_r;
    vh_nxt        = vh_r;
    tw_nxt        = tw_r;
    th_nxt        = th_r;
    tp_nxt        = tp_r;
    dist_nxt      = dist_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    side_nxt      = side_r;
    column_x_nxt  = column_x_r;
    base_nxt      = base_r;
    texel_col_nxt = texel_col_r;
    top_row_nxt   = top_row_r;
    rows_left_nxt = rows_left_r;
    row_done_nxt  = row_done_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    div_start = 1'b0;
    div_n     = DIV_N_W'(ps_r);
    div_d     = dist_r;
    // idle default keeps trow * pitch ready for the next row tick
    mul_a     = $signed(MUL_A_W'(trow));
    mul_b     = $signed(MUL_B_W'(tp_r));

    if (cfg_we) begin
      case (cfg_index)
        CFG_PLAYER_X:   px_nxt = cfg_data[POS_W-1:0];
        CFG_PLAYER_Y:   py_nxt = cfg_data[POS_W-1:0];
        CFG_VIEW_H:     vh_nxt = cfg_data[ROW_W-1:0];
        CFG_PROJ_SCALE: ps_nxt = cfg_data[POS_W-1:0];
        CFG_TEX_W:      tw_nxt = cfg_data[TEX_W-1:0];
        CFG_TEX_H:      th_nxt = cfg_data[TEX_W-1:0];
        CFG_TEX_PITCH:  tp_nxt = cfg_data[TEX_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == OP_START) begin
            dist_nxt     = in_data.ray_distance;
            dir_x_nxt    = in_data.ray_dir_x;
            dir_y_nxt    = in_data.ray_dir_y;
            side_nxt     = in_data.ray_side;
            base_nxt     = in_data.texture_base;
            column_x_nxt = PIX_X_W'(32'(in_data.column_index) * 32'(STRIP_WIDTH));
            state_nxt    = S_HIT;
          end else if (rows_left_r != '0) begin
            state_nxt = S_ROUT;
          end
        end
      end
      S_HIT: begin
        mul_a     = $signed({1'b0, dist_r});
        mul_b     = MUL_B_W'(side_r ? dir_x_r : dir_y_r);
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        mul_a     = $signed(MUL_A_W'(frac));
        mul_b     = $signed(MUL_B_W'(tw_r));
        state_nxt = S_COL;
      end
      S_COL: begin
        texel_col_nxt = mirror ? col_mir[ROW_W-1:0] : col_raw[ROW_W-1:0];
        div_start     = 1'b1;
        state_nxt     = S_DIVH;
      end
      S_DIVH: begin
        if (div_done) begin
          if (div_h == '0) begin
            rows_left_nxt = '0;
            row_done_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            h_nxt     = div_h;
            div_start = 1'b1;
            div_n     = {th_r, {STEP_FRAC{1'b0}}};
            div_d     = DIV_D_W'(div_h);
            state_nxt = S_DIVS;
          end
        end
      end
      S_DIVS: begin
        if (div_done) begin
          step_nxt    = ACC_W'(div_q);
          top_row_nxt = ROW_W'(top);
          mul_a       = $signed(MUL_A_W'(off));
          mul_b       = $signed(MUL_B_W'(div_q));
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        acc_nxt       = mul_p;
        rows_left_nxt = (h_r > vh_r) ? (vh_r - 12'd1) : h_r;
        row_done_nxt  = '0;
        state_nxt     = S_IDLE;
      end
      S_ROUT: begin
        // hold here while the previous result is still waiting
        if (out_load) begin
          out_nxt.pixel_x       = column_x_r;
          out_nxt.pixel_y       = top_row_r + row_done_r;
          out_nxt.texel_address = base_r + ADDR_W'(mul_p[2*TEX_W-1:0])
                                + ADDR_W'(texel_col_r);
          out_nxt.last_row      = (rows_left_r == 12'd1);
          out_valid_nxt         = 1'b1;
          acc_nxt               = acc_r + step_r;
          row_done_nxt          = row_done_r + 12'd1;
          rows_left_nxt         = rows_left_r - 12'd1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      px_r        <= '0;
      py_r        <= '0;
      ps_r        <= '0;
      vh_r        <= VIEW_H_RST;
      tw_r        <= TEX_RST;
      th_r        <= TEX_RST;
      tp_r        <= TEX_RST;
      rows_left_r <= '0;
      row_done_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      ps_r        <= ps_nxt;
      vh_r        <= vh_nxt;
      tw_r        <= tw_nxt;
      th_r        <= th_nxt;
      tp_r        <= tp_nxt;
      rows_left_r <= rows_left_nxt;
      row_done_r  <= row_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dist_r      <= dist_nxt;
    dir_x_r     <= dir_x_nxt;
    dir_y_r     <= dir_y_nxt;
    side_r      <= side_nxt;
    column_x_r  <= column_x_nxt;
    base_r      <= base_nxt;
    texel_col_r <= texel_col_nxt;
    top_row_r   <= top_row_nxt;
    h_r         <= h_nxt;
    acc_r       <= acc_nxt;
    step_r      <= step_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // divider is never restarted mid-divide
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // divide results only land in the states that wait for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVH || state_r == S_DIVS))
    else $error("divider finished outside a wait state");

  // a row is only emitted for an active column
  a_rout_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUT |-> rows_left_r != '0)
    else $error("row emit with no active column");

  // a tick with no active column leaves the block idle and inactive
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_ROW && rows_left_r == '0
    |=> state_r == S_IDLE && rows_left_r == '0)
    else $error("idle row tick changed state");

endmodule

`default_nettype wire

[hdl/rwc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module rwc_div
  import rwc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_ITER = DIV_CNT_W'(DIV_N_W - 1);

  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // trial subtract of the shifted partial remainder
  assign diff = {1'b0, rem_r, quo_r[DIV_N_W-1]} - {2'b00, dvs_r};
  assign ge   = !diff[DIV_D_W+1];

  always_comb begin
    rem_nxt = ge ? diff[DIV_D_W-1:0] : {rem_r[DIV_D_W-2:0], quo_r[DIV_N_W-1]};
    quo_nxt = {quo_r[DIV_N_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hdl/rwc_mul.sv]
// Shared signed multiplier with registered product (low bits kept).
`default_nettype none

module rwc_mul
  import rwc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0]             p
);

  logic signed [MUL_A_W+MUL_B_W-1:0] full;
  logic [MUL_P_W-1:0]                p_r;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p_r <= full[MUL_P_W-1:0];
  end

  assign p = p_r;

endmodule

`default_nettype wire
